/* rtl/ubxr_pkg.sv */
// Shared types and constants for the UBX frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package ubxr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd1;

    localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1024;
    localparam logic [15:0] TIMEOUT_RST     = 16'd10;

    localparam int TDATA_W = 56;

    typedef enum logic [1:0] {
        BYTE_OTHER = 2'd0,
        BYTE_IDLE  = 2'd1,
        BYTE_SYNC1 = 2'd2,
        BYTE_SYNC2 = 2'd3
    } byte_cls_t;

    typedef struct packed {
        byte_cls_t  cls;
        logic [7:0] data;
    } q_item_t;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CKA     = 3'd4,
        PH_CKB     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_OK      = 3'd1,
        KIND_BADSUM  = 3'd2,
        KIND_TOOLONG = 3'd3,
        KIND_TIMEOUT = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [9:0]  byte_index;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_len;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

/* rtl/ubxr_front.sv */
// Front end: takes input beats, tags each byte (idle, sync, other)
// and pushes it into the item queue. Depends on ubxr_pkg.
`default_nettype none

module ubxr_front
    import ubxr_pkg::*;
(
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       q_full,
    output logic            q_push,
    output q_item_t         q_item
);

    always_comb begin
        unique case (s_tdata)
            IDLE_BYTE:   q_item.cls = BYTE_IDLE;
            SYNC_FIRST:  q_item.cls = BYTE_SYNC1;
            SYNC_SECOND: q_item.cls = BYTE_SYNC2;
            default:     q_item.cls = BYTE_OTHER;
        endcase
        q_item.data = s_tdata;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

/* rtl/ubxr_queue.sv */
// Short item queue between front end and parser.
// Depends on ubxr_pkg for the item type and depth.
`default_nettype none

module ubxr_queue
    import ubxr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  q_item_t   push_item,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output q_item_t   head_item
);

    q_item_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;
    logic                  do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ubxr_back.sv */
// Back end: frame parser FSM, Fletcher sums, config registers and
// the registered result slot. Depends on ubxr_pkg.
`default_nettype none

module ubxr_back
    import ubxr_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  q_valid,
    input  q_item_t                    q_item,
    output logic                       q_pop,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output res_t                       res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [16:0] LIMIT_CAP = 17'(MAX_PAYLOAD_BYTES);

    logic [10:0]      max_payload_reg;
    logic [15:0]      timeout_polls_reg;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       frame_class_reg, frame_class_next;
    logic [7:0]       frame_id_reg, frame_id_next;
    logic [15:0]      frame_length_reg, frame_length_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [7:0]       check_a_reg, check_a_next;
    logic [15:0]      idle_count_reg, idle_count_next;

    logic             out_valid_reg;
    res_t             out_reg;

    logic             step;
    logic [7:0]       b;
    logic [7:0]       sum_a_upd;
    logic             timeout_hit;
    logic [15:0]      full_len;
    logic [16:0]      limit;
    logic             too_long;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      cnt16;

    logic             r_valid;
    res_t             r;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg   <= MAX_PAYLOAD_RST;
            timeout_polls_reg <= TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg   <= cfg_data[10:0];
                REG_TIMEOUT:     timeout_polls_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // one queued byte per cycle whenever the result slot is free or draining
    assign step  = q_valid && (!out_valid_reg || res_ready);
    assign q_pop = step;
    assign b     = q_item.data;

    assign sum_a_upd   = sum_a_reg + b;
    assign timeout_hit = (idle_count_reg >= timeout_polls_reg);
    assign full_len    = {b, frame_length_reg[7:0]};
    assign limit       = ({6'd0, max_payload_reg} > LIMIT_CAP) ? LIMIT_CAP
                                                               : {6'd0, max_payload_reg};
    assign too_long    = ({1'b0, full_len} > limit);
    assign cnt_inc     = byte_count_reg + 1'b1;
    assign cnt16       = 16'(byte_count_reg);

    // next state
    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        frame_class_next  = frame_class_reg;
        frame_id_next     = frame_id_reg;
        frame_length_next = frame_length_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        check_a_next      = check_a_reg;
        idle_count_next   = idle_count_reg;
        unique case (phase_reg)
            PH_HUNT1, PH_HUNT2: begin
                if (q_item.cls == BYTE_IDLE) begin
                    if (timeout_hit) begin
                        idle_count_next = '0;
                        phase_next      = PH_HUNT1;
                    end else begin
                        idle_count_next = idle_count_reg + 1'b1;
                    end
                end else if (phase_reg == PH_HUNT1) begin
                    if (q_item.cls == BYTE_SYNC1) begin
                        phase_next = PH_HUNT2;
                    end
                end else if (q_item.cls == BYTE_SYNC2) begin
                    phase_next        = PH_HEADER;
                    byte_count_next   = '0;
                    sum_a_next        = '0;
                    sum_b_next        = '0;
                    idle_count_next   = '0;
                    frame_class_next  = '0;
                    frame_id_next     = '0;
                    frame_length_next = '0;
                end else begin
                    // broken sync: byte is dropped, not rechecked as a first sync
                    phase_next = PH_HUNT1;
                end
            end
            PH_HEADER: begin
                sum_a_next = sum_a_upd;
                sum_b_next = sum_b_reg + sum_a_upd;
                if (cnt16 == 16'd3) begin
                    frame_length_next = full_len;
                    byte_count_next   = '0;
                    if (too_long) begin
                        phase_next = PH_HUNT1;
                    end else if (full_len == '0) begin
                        phase_next = PH_CKA;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end else begin
                    byte_count_next = cnt_inc;
                    case (cnt16)
                        16'd0:   frame_class_next  = b;
                        16'd1:   frame_id_next     = b;
                        default: frame_length_next = {8'd0, b};
                    endcase
                end
            end
            PH_PAYLOAD: begin
                sum_a_next = sum_a_upd;
                sum_b_next = sum_b_reg + sum_a_upd;
                if (17'(cnt_inc) >= {1'b0, frame_length_reg}) begin
                    byte_count_next = '0;
                    phase_next      = PH_CKA;
                end else begin
                    byte_count_next = cnt_inc;
                end
            end
            PH_CKA: begin
                check_a_next = b;
                phase_next   = PH_CKB;
            end
            PH_CKB: begin
                phase_next      = PH_HUNT1;
                byte_count_next = '0;
            end
            default: phase_next = PH_HUNT1;
        endcase
    end

    // result for the byte being consumed
    always_comb begin
        r_valid      = 1'b0;
        r.kind       = KIND_DATA;
        r.data_byte  = '0;
        r.byte_index = '0;
        r.msg_class  = frame_class_reg;
        r.msg_id     = frame_id_reg;
        r.msg_len    = frame_length_reg;
        r.last       = 1'b0;
        unique case (phase_reg)
            PH_HUNT1, PH_HUNT2: begin
                if (q_item.cls == BYTE_IDLE && timeout_hit) begin
                    r_valid     = 1'b1;
                    r.kind      = KIND_TIMEOUT;
                    r.msg_class = '0;
                    r.msg_id    = '0;
                    r.msg_len   = '0;
                end
            end
            PH_HEADER: begin
                if (cnt16 == 16'd3 && too_long) begin
                    r_valid   = 1'b1;
                    r.kind    = KIND_TOOLONG;
                    r.msg_len = full_len;
                    r.last    = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                r_valid      = 1'b1;
                r.data_byte  = b;
                r.byte_index = cnt16[9:0];
            end
            PH_CKB: begin
                r_valid = 1'b1;
                r.kind  = (check_a_reg == sum_a_reg && b == sum_b_reg) ? KIND_OK
                                                                       : KIND_BADSUM;
                r.last  = 1'b1;
            end
            default: r_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT1;
            byte_count_reg   <= '0;
            frame_class_reg  <= '0;
            frame_id_reg     <= '0;
            frame_length_reg <= '0;
            sum_a_reg        <= '0;
            sum_b_reg        <= '0;
            check_a_reg      <= '0;
            idle_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (step) begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                frame_class_reg  <= frame_class_next;
                frame_id_reg     <= frame_id_next;
                frame_length_reg <= frame_length_next;
                sum_a_reg        <= sum_a_next;
                sum_b_reg        <= sum_b_next;
                check_a_reg      <= check_a_next;
                idle_count_reg   <= idle_count_next;
                out_valid_reg    <= r_valid;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && r_valid) begin
            out_reg <= r;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

/* rtl/ubx_frame_receiver.sv */
// Top level of the UBX frame receiver: front end, item queue, parser.
// Depends on ubxr_pkg, ubxr_front, ubxr_queue and ubxr_back.
//
// Usage:
//  - s_ channel: one received byte per beat in s_tdata. While hunting
//    for the 0xB5 0x62 sync pair, 0xFF is an idle poll; more idle polls
//    than timeout_polls give a timeout result.
//  - m_ channel: at most one result beat per input byte. m_tuser holds
//    the kind (payload byte, frame ok, checksum bad, too long, timeout),
//    m_tlast marks the status beat that ends a frame.
//  - cfg_ channel: register 0 is max_payload, 1 is timeout_polls; always
//    ready, write only while the block is idle.
//  - Path: a taken byte is written into the queue, then consumed by the
//    parser, whose result register drives the result beat on m_.
//  - Throughput: one byte per cycle while m_ drains; the parser consumes
//    one queued byte per cycle; per byte it does one add chain and compare.
//  - Stall: with m_tready low the result register holds; the four-entry
//    queue keeps taking bytes until full, then s_tready drops.
//  - Reset (aresetn low, synchronous): queue empty, parser hunting for
//    the first sync byte, registers back to 1024 and 10.
`default_nettype none

module ubx_frame_receiver
    import ubxr_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
    // result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] data_byte, [17:8] byte_index, [25:18] msg_class,
    // [33:26] msg_id, [49:34] msg_len, [55:50] zero
    output logic [TDATA_W-1:0]         m_tdata,
    output logic [2:0]                 m_tuser,   // [2:0] kind
    output logic                       m_tlast,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    q_item_t in_item;
    q_item_t head_item;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_not_empty;
    res_t    res;

    ubxr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (in_item)
    );

    ubxr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (in_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    ubxr_back #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_not_empty),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack the result beat, first field in the low bits
    assign m_tdata = {6'd0, res.msg_len, res.msg_id, res.msg_class,
                      res.byte_index, res.data_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire
